/* hdl/dmg_pkg.sv */
// ----------------------------------------------------------------------------
// dmg_pkg
// Shared widths, register indexes, rule codes and default parameter values
// for the divisibility mask generator.
// ----------------------------------------------------------------------------
package dmg_pkg;

   // port payload widths
   localparam int EXPONENT_BITS  = 16;
   localparam int MASK_BITS      = 64;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;
   localparam int RULE_BITS      = 3;
   localparam int NUM_INDETS_BITS = 9;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RULE_SELECT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_INDETS  = 2'd1;

   // rule codes, anything else behaves as the null rule
   localparam logic [RULE_BITS-1:0] RULE_NULL        = 3'd0;
   localparam logic [RULE_BITS-1:0] RULE_SINGLE      = 3'd1;
   localparam logic [RULE_BITS-1:0] RULE_SINGLE_WRAP = 3'd2;
   localparam logic [RULE_BITS-1:0] RULE_EVEN_POWERS = 3'd3;
   localparam logic [RULE_BITS-1:0] RULE_HASH        = 3'd4;

   // hashing stride: (HASH_STEP_MULT * (v / W) + HASH_STEP_BASE) mod W
   localparam int HASH_STEP_MULT = 24;
   localparam int HASH_STEP_BASE = 13;

   // parameter defaults
   localparam int MASK_WIDTH_DEFAULT = 64;
   localparam int EXP_BITS_DEFAULT   = 16;
   localparam int MAX_VARS_DEFAULT   = 256;

endpackage

/* hdl/dmg_req_if.sv */
// ----------------------------------------------------------------------------
// dmg_req_if
// Exponent channel: one exponent per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmg_req_if;
   logic                               valid;
   logic                               ready;
   logic [dmg_pkg::EXPONENT_BITS-1:0]  exponent;

   modport source (output valid, output exponent, input ready);
   modport sink   (input valid, input exponent, output ready);
endinterface

/* hdl/dmg_rsp_if.sv */
// ----------------------------------------------------------------------------
// dmg_rsp_if
// Mask channel: one finished divisibility mask per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dmg_pkg::MASK_BITS-1:0]  mask;

   modport source (output valid, output mask, input ready);
   modport sink   (input valid, input mask, output ready);
endinterface

/* hdl/divisibility_mask_generator_unit.sv */
// ----------------------------------------------------------------------------
// divisibility_mask_generator_unit
// Builds a divisibility mask from a monomial's exponents, one exponent a beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one exponent per beat, variable 0 first. After num_indets
//   beats the accumulated mask goes out as one beat on rsp_bus and the
//   accumulator clears for the next monomial.
//   csr_* writes rule_select (index 0) or num_indets (index 1); a write to
//   either index also restarts the monomial. Write only while the block is idle.
// Timing:
//   every exponent runs through a small sequencer: accept, work, finish.
//   null and single-bit rules: at most one mask bit per exponent.
//   even powers: bits v + b*n while they fit in W (bit v mod W when n > W).
//   hashing: strided bits while e exceeds the squared counter, at most MASK_WIDTH bits.
//   The work cycles are iterations of one shared index adder (stride add,
//   modulo-W wrap for hashing) and one exponent comparator, one mask bit per cycle.
//   req_bus.ready is high only in the accept state.
// Reset and stall:
//   reset clears the accumulator and position, selects the null rule and
//   sets num_indets to 1. A finished mask is held in an output register; a
//   stalled receiver only blocks the block at the end of the next monomial.
// ----------------------------------------------------------------------------
module divisibility_mask_generator_unit #(
   parameter int MASK_WIDTH = dmg_pkg::MASK_WIDTH_DEFAULT,
   parameter int EXP_BITS   = dmg_pkg::EXP_BITS_DEFAULT,
   parameter int MAX_VARS   = dmg_pkg::MAX_VARS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dmg_req_if.sink                              req_bus,
   dmg_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_en,
   input  logic [dmg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dmg_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int W        = MASK_WIDTH;
   localparam int EB       = (EXP_BITS < dmg_pkg::EXPONENT_BITS) ? EXP_BITS
                                                                 : dmg_pkg::EXPONENT_BITS;
   localparam int N_LIMIT  = (1 << dmg_pkg::NUM_INDETS_BITS) - 1;
   localparam int N_MAX    = (MAX_VARS < N_LIMIT) ? MAX_VARS : N_LIMIT;
   localparam int N_BITS   = $clog2(N_MAX + 1);
   localparam int POS_BITS = (N_MAX > 1) ? $clog2(N_MAX) : 1;
   localparam int MOD_BITS = $clog2(W);
   localparam int SUM_BITS = $clog2(W + N_MAX + 1);
   localparam int CNT_BITS = $clog2(W + 1);
   localparam int SQ_BITS  = $clog2(W * W + 1);
   localparam int CMP_A    = (EB > SQ_BITS) ? EB : SQ_BITS;
   localparam int CMP_BITS = (CMP_A > CNT_BITS + 1) ? CMP_A : CNT_BITS + 1;
   localparam int STEP_INIT = dmg_pkg::HASH_STEP_BASE % W;
   localparam int STEP_INC  = dmg_pkg::HASH_STEP_MULT % W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [dmg_pkg::RULE_BITS-1:0]      rule_ff, rule_in;
   logic [N_BITS-1:0]                  nvars_ff, nvars_in;
   logic [W-1:0]                       acc_ff, acc_in;
   logic [POS_BITS-1:0]                pos_ff, pos_in;
   logic [MOD_BITS-1:0]                pos_mod_ff, pos_mod_in;
   logic [MOD_BITS-1:0]                step_ff, step_in;
   logic [EB-1:0]                      exp_ff, exp_in;
   logic [SUM_BITS-1:0]                idx_ff, idx_in;
   logic [CNT_BITS-1:0]                rem_ff, rem_in;
   logic [CNT_BITS-1:0]                cnt_ff, cnt_in;
   logic [SQ_BITS-1:0]                 sq_ff, sq_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [dmg_pkg::MASK_BITS-1:0]      rsp_mask_ff, rsp_mask_in;

   logic                               is_hash;
   logic [CMP_BITS-1:0]                thr;
   logic                               exp_gt_thr;
   logic                               exp_nz;
   logic                               exp_gt1;
   logic [SUM_BITS-1:0]                add_b;
   logic [SUM_BITS-1:0]                sum;
   logic [SUM_BITS-1:0]                sum_wrap;
   logic                               n_fits;
   logic                               wide_vars;
   logic                               idx_in_range;
   logic                               pos_in_range;
   logic                               last_var;
   logic [MOD_BITS:0]                  step_sum;
   logic [MOD_BITS-1:0]                step_adv;
   logic                               set_en;
   logic [MOD_BITS-1:0]                set_pos;
   logic [W-1:0]                       acc_set;
   logic                               csr_hit;
   logic [N_BITS-1:0]                  nvars_clamped;

   // shared exponent comparator: squared counter for hashing, 2b for even powers
   assign is_hash    = (rule_ff == dmg_pkg::RULE_HASH);
   assign thr        = is_hash ? CMP_BITS'(sq_ff) : CMP_BITS'({cnt_ff, 1'b0});
   assign exp_gt_thr = CMP_BITS'(exp_ff) > thr;
   assign exp_nz     = |exp_ff;
   assign exp_gt1    = |exp_ff[EB-1:1];

   // shared index adder: stride add with modulo-W wrap for hashing
   assign add_b    = is_hash ? SUM_BITS'(step_ff) : SUM_BITS'(nvars_ff);
   assign sum      = idx_ff + add_b;
   assign sum_wrap = (is_hash && (sum >= SUM_BITS'(W))) ? sum - SUM_BITS'(W) : sum;

   assign n_fits       = SUM_BITS'(nvars_ff) <= SUM_BITS'(rem_ff);
   assign wide_vars    = SUM_BITS'(nvars_ff) > SUM_BITS'(W);
   assign idx_in_range = idx_ff < SUM_BITS'(W);
   assign pos_in_range = SUM_BITS'(pos_ff) < SUM_BITS'(W);
   assign last_var     = (SUM_BITS'(pos_ff) + SUM_BITS'(1)) >= SUM_BITS'(nvars_ff);

   // stride grows by 24 mod W each time the position wraps past W
   assign step_sum = (MOD_BITS + 1)'(step_ff) + (MOD_BITS + 1)'(STEP_INC);
   assign step_adv = (step_sum >= (MOD_BITS + 1)'(W)) ?
                     MOD_BITS'(step_sum - (MOD_BITS + 1)'(W)) : MOD_BITS'(step_sum);

   assign csr_hit = csr_write_en &&
                    ((csr_index == dmg_pkg::CSR_RULE_SELECT) ||
                     (csr_index == dmg_pkg::CSR_NUM_INDETS));

   always_comb begin
      if (csr_data == '0) begin
         nvars_clamped = N_BITS'(1);
      end else if ({1'b0, csr_data} > (dmg_pkg::CSR_DATA_BITS + 1)'(N_MAX)) begin
         nvars_clamped = N_BITS'(N_MAX);
      end else begin
         nvars_clamped = N_BITS'(csr_data);
      end
   end

   assign acc_set = acc_ff | (set_en ? (W'(1) << set_pos) : '0);

   always_comb begin
      state_in     = state_ff;
      rule_in      = rule_ff;
      nvars_in     = nvars_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      pos_mod_in   = pos_mod_ff;
      step_in      = step_ff;
      exp_in       = exp_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      set_en       = 1'b0;
      set_pos      = '0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               exp_in   = req_bus.exponent[EB-1:0];
               cnt_in   = '0;
               sq_in    = '0;
               rem_in   = CNT_BITS'(W);
               idx_in   = is_hash ? SUM_BITS'(pos_mod_ff) : SUM_BITS'(pos_ff);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            case (rule_ff)
               dmg_pkg::RULE_SINGLE: begin
                  set_en   = exp_nz && pos_in_range;
                  set_pos  = pos_mod_ff;
                  state_in = ST_FIN;
               end
               dmg_pkg::RULE_SINGLE_WRAP: begin
                  set_en   = exp_nz;
                  set_pos  = pos_mod_ff;
                  state_in = ST_FIN;
               end
               dmg_pkg::RULE_EVEN_POWERS: begin
                  if (wide_vars) begin
                     set_en   = exp_nz;
                     set_pos  = pos_mod_ff;
                     state_in = ST_FIN;
                  end else if (n_fits) begin
                     // one threshold 2b per cycle, bit v + b*n
                     set_en  = exp_gt_thr;
                     set_pos = idx_ff[MOD_BITS-1:0];
                     idx_in  = sum;
                     rem_in  = CNT_BITS'(SUM_BITS'(rem_ff) - SUM_BITS'(nvars_ff));
                     cnt_in  = cnt_ff + CNT_BITS'(1);
                  end else begin
                     // leftover bit: exponent greater than one
                     set_en   = exp_gt1 && idx_in_range;
                     set_pos  = idx_ff[MOD_BITS-1:0];
                     state_in = ST_FIN;
                  end
               end
               dmg_pkg::RULE_HASH: begin
                  if ((cnt_ff < CNT_BITS'(W)) && exp_gt_thr) begin
                     set_en  = 1'b1;
                     set_pos = idx_ff[MOD_BITS-1:0];
                     idx_in  = sum_wrap;
                     sq_in   = sq_ff + SQ_BITS'({cnt_ff, 1'b1});
                     cnt_in  = cnt_ff + CNT_BITS'(1);
                  end else begin
                     state_in = ST_FIN;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
            acc_in = acc_set;
         end
         ST_FIN: begin
            if (last_var) begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_mask_in  = dmg_pkg::MASK_BITS'(acc_ff);
                  rsp_valid_in = 1'b1;
                  acc_in       = '0;
                  pos_in       = '0;
                  pos_mod_in   = '0;
                  step_in      = MOD_BITS'(STEP_INIT);
                  state_in     = ST_IDLE;
               end
            end else begin
               pos_in = pos_ff + POS_BITS'(1);
               if (pos_mod_ff == MOD_BITS'(W - 1)) begin
                  pos_mod_in = '0;
                  step_in    = step_adv;
               end else begin
                  pos_mod_in = pos_mod_ff + MOD_BITS'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_hit) begin
         if (csr_index == dmg_pkg::CSR_RULE_SELECT) begin
            rule_in = csr_data[dmg_pkg::RULE_BITS-1:0];
         end else begin
            nvars_in = nvars_clamped;
         end
         acc_in     = '0;
         pos_in     = '0;
         pos_mod_in = '0;
         step_in    = MOD_BITS'(STEP_INIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rule_ff      <= dmg_pkg::RULE_NULL;
         nvars_ff     <= N_BITS'(1);
         acc_ff       <= '0;
         pos_ff       <= '0;
         pos_mod_ff   <= '0;
         step_ff      <= MOD_BITS'(STEP_INIT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rule_ff      <= rule_in;
         nvars_ff     <= nvars_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         pos_mod_ff   <= pos_mod_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff      <= exp_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      sq_ff       <= sq_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.mask  = rsp_mask_ff;

endmodule
